### hw/rtl/itt_pkg.sv
// Shared types and constants for the inversion-count trend test.
// No dependencies.
package itt_pkg;

  localparam int unsigned SAMPLE_FIELD_W = 16;
  localparam int unsigned COUNT_W        = 19;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned IN_TDATA_W     = 16;
  localparam int unsigned OUT_TDATA_W    = 24;

  localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;
  localparam logic [COUNT_W-1:0] BAND_LOW_RST   = COUNT_W'(239412);
  localparam logic [COUNT_W-1:0] BAND_HIGH_RST  = COUNT_W'(260088);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BAND_LOW  = 2'd0,
    CFG_BAND_HIGH = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    VERDICT_NONE = 2'd0,
    VERDICT_RISE = 2'd1,
    VERDICT_FALL = 2'd2
  } verdict_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_WRITE = 4'b0100,
    ST_FIN   = 4'b1000
  } state_e;

  typedef struct packed {
    logic load;
    logic rd;
    logic wr;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic full;
    logic last;
    logic out_busy;
  } dp_sts_t;

endpackage

### hw/rtl/inversion_trend_test.sv
// Inversion-count trend test. Every sample already stored in the series is read
// in turn before the next sample transfer is accepted: one store read per cycle
// feeds the single comparator. With the store full a sample is dropped and no
// scan is made. The result of a last sample goes to the output register, held
// back while the previous result still waits. Reset (async, active low) clears
// the series, band, output valid and controller state, but not the output data.
module inversion_trend_test
  import itt_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = 1024,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [15:0] sample
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [18:0] pair_count, [20:19] verdict
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [COUNT_W-1:0]     cfg_data_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  itt_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  itt_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .s_tdata_i   (s_axis_tdata),
    .s_tlast_i   (s_axis_tlast),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .m_tready_i  (m_axis_tready),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tdata_o   (m_axis_tdata)
  );

endmodule

### hw/rtl/itt_datapath.sv
// Datapath: sample store, scan counter, comparator, pair counter, band
// registers and output register. Depends on itt_pkg.
module itt_datapath
  import itt_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = 1024,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dp_cmd_t                cmd_i,
  output dp_sts_t                sts_o,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,
  input  logic                   s_tlast_i,
  input  logic                   cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [COUNT_W-1:0]     cfg_data_i,
  input  logic                   m_tready_i,
  output logic                   m_tvalid_o,
  output logic [OUT_TDATA_W-1:0] m_tdata_o
);

  localparam int unsigned IDX_W  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned ADDR_W = $clog2(MAX_SAMPLES);

  logic [SAMPLE_BITS-1:0] mem_q [MAX_SAMPLES];
  logic [SAMPLE_BITS-1:0] raw;
  logic [SAMPLE_BITS-1:0] v_q, rd_q;
  logic                   last_q, cmp_vld_q;
  logic [IDX_W-1:0]       idx_q, k_q;
  logic [COUNT_W-1:0]     count_q, band_lo_q, band_hi_q, out_count_q;
  logic                   out_valid_q;
  verdict_e               verdict, out_verdict_q;

  if (SAMPLE_BITS <= SAMPLE_FIELD_W) begin : g_trunc
    assign raw = s_tdata_i[SAMPLE_BITS-1:0];
  end else begin : g_ext
    assign raw = {{(SAMPLE_BITS-SAMPLE_FIELD_W){s_tdata_i[SAMPLE_FIELD_W-1]}}, s_tdata_i};
  end

  // biased storage: unsigned order equals signed order
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v_q <= raw ^ {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end
    if (cmd_i.wr) begin
      mem_q[idx_q[ADDR_W-1:0]] <= v_q;
    end
    if (cmd_i.rd) begin
      rd_q <= mem_q[k_q[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= 1'b0;
      cmp_vld_q <= 1'b0;
      idx_q     <= '0;
      k_q       <= '0;
      count_q   <= '0;
    end else begin
      cmp_vld_q <= cmd_i.rd;
      if (cmd_i.load) begin
        last_q <= s_tlast_i;
        k_q    <= '0;
      end else if (cmd_i.rd) begin
        k_q <= k_q + IDX_W'(1);
      end
      if (cmd_i.emit) begin
        idx_q <= '0;
      end else if (cmd_i.wr) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      if (cmd_i.emit) begin
        count_q <= '0;
      end else if (cmp_vld_q && (v_q > rd_q) && (count_q != COUNT_MAX)) begin
        count_q <= count_q + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_lo_q <= BAND_LOW_RST;
      band_hi_q <= BAND_HIGH_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_BAND_LOW:  band_lo_q <= cfg_data_i;
        CFG_BAND_HIGH: band_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (count_q > band_hi_q) begin
      verdict = VERDICT_RISE;
    end else if (count_q < band_lo_q) begin
      verdict = VERDICT_FALL;
    end else begin
      verdict = VERDICT_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_count_q   <= count_q;
      out_verdict_q <= verdict;
    end
  end

  assign sts_o.scan_done = (k_q == idx_q);
  assign sts_o.full      = (idx_q == IDX_W'(MAX_SAMPLES));
  assign sts_o.last      = last_q;
  assign sts_o.out_busy  = out_valid_q && !m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {{(OUT_TDATA_W-COUNT_W-2){1'b0}}, out_verdict_q, out_count_q};

endmodule

### hw/rtl/itt_controller.sv
// Controller FSM: sequences load, scan, store and result transfer.
// Depends on itt_pkg.
module itt_controller
  import itt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_tvalid_i,
  output logic    s_tready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.full) begin
          state_d = ST_FIN;
        end else if (!sts_i.scan_done) begin
          cmd_o.rd = 1'b1;
        end else begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd_o.wr = 1'b1;
        state_d  = ST_FIN;
      end
      ST_FIN: begin
        if (!sts_i.last) begin
          state_d = ST_IDLE;
        end else if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### hw/rtl/itt_checker.sv
// Port-level checks for inversion_trend_test, attached by bind.
// Depends on itt_pkg.
module itt_checker
  import itt_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[20:19] == VERDICT_NONE ||
                       m_axis_tdata[20:19] == VERDICT_RISE ||
                       m_axis_tdata[20:19] == VERDICT_FALL))
    else $error("bad verdict code");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready during scan");

endmodule

bind inversion_trend_test itt_checker u_itt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### sim/tb_inversion_trend_test.sv
// Self-checking testbench for inversion_trend_test: drives sample series over the
// input stream, predicts pair count and verdict, and checks each result transfer.
// Depends on itt_pkg and the inversion_trend_test RTL.
`timescale 1ns / 1ps

module tb_inversion_trend_test;
  import itt_pkg::*;

  localparam int unsigned SERIES_DEPTH  = 1024;
  localparam int unsigned SAMPLE_W      = 16;
  localparam int          RAND_ITEMS    = 520;
  localparam int          RAND_PHASES   = 4;
  localparam int          SETTLE_CYCLES = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } sample_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] pair_count;
    logic [1:0]         verdict;
  } trend_result_t;

  logic                   clk_i;
  logic                   rst_ni         = 1'b0;
  logic                   s_axis_tvalid  = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata   = '0;  // [15:0] sample
  logic                   s_axis_tlast   = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;  // [18:0] pair_count, [20:19] verdict
  logic                   cfg_valid_i    = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i    = '0;
  logic [COUNT_W-1:0]     cfg_data_i     = '0;

  sample_item_t  pending_samples[$];
  trend_result_t trend_results_q[$];

  // predictor state
  logic signed [SAMPLE_W-1:0] series_mem[SERIES_DEPTH];
  int                         series_len = 0;
  logic [COUNT_W-1:0]         run_pairs  = '0;
  logic [COUNT_W-1:0]         band_lo    = BAND_LOW_RST;
  logic [COUNT_W-1:0]         band_hi    = BAND_HIGH_RST;

  int fail_count   = 0;
  int samples_sent = 0;
  int series_sent  = 0;
  int results_seen = 0;
  int band_writes  = 0;

  logic         sample_taken = 1'b0;
  sample_item_t drv_item;
  int           burst_left = 0;
  int           gap_left   = 0;
  int           stall_mode = 0;
  int           stall_left = 0;
  trend_result_t got_exp;

  inversion_trend_test #(
    .MAX_SAMPLES(SERIES_DEPTH),
    .SAMPLE_BITS(SAMPLE_W)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void absorb_sample(input logic signed [SAMPLE_W-1:0] smp,
                                        input logic is_last);
    trend_result_t res;
    if (series_len < SERIES_DEPTH) begin
      for (int k = 0; k < series_len; k++) begin
        if (smp > series_mem[k] && run_pairs < COUNT_MAX) run_pairs++;
      end
      series_mem[series_len] = smp;
      series_len++;
    end
    if (is_last) begin
      res.pair_count = run_pairs;
      if (run_pairs > band_hi) res.verdict = VERDICT_RISE;
      else if (run_pairs < band_lo) res.verdict = VERDICT_FALL;
      else res.verdict = VERDICT_NONE;
      trend_results_q.push_back(res);
      series_len = 0;
      run_pairs  = '0;
    end
  endfunction

  // sender: bursts of random length, random gaps after each burst
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || sample_taken) begin
      if (gap_left != 0 || pending_samples.size() == 0) begin
        if (gap_left != 0) gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else begin
        drv_item = pending_samples.pop_front();
        s_axis_tdata  <= drv_item.sample;
        s_axis_tlast  <= drv_item.last;
        s_axis_tvalid <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          case ($urandom_range(0, 3))
            0, 1:    gap_left <= 0;
            2:       gap_left <= $urandom_range(1, 4);
            default: gap_left <= $urandom_range(5, 40);
          endcase
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver: stall pattern switches between always ready, coin flip and sparse
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(16, 256);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    sample_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      absorb_sample(s_axis_tdata[SAMPLE_W-1:0], s_axis_tlast);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (trend_results_q.size() == 0) begin
        $error("unexpected result transfer: pair_count %0d verdict %0d",
               m_axis_tdata[COUNT_W-1:0], m_axis_tdata[COUNT_W+1:COUNT_W]);
        fail_count++;
      end else begin
        got_exp = trend_results_q.pop_front();
        if (m_axis_tdata[COUNT_W-1:0] != got_exp.pair_count) begin
          $error("pair_count mismatch: expected %0d, actual %0d",
                 got_exp.pair_count, m_axis_tdata[COUNT_W-1:0]);
          fail_count++;
        end
        if (m_axis_tdata[COUNT_W+1:COUNT_W] != got_exp.verdict) begin
          $error("verdict mismatch: expected %0d, actual %0d",
                 got_exp.verdict, m_axis_tdata[COUNT_W+1:COUNT_W]);
          fail_count++;
        end
      end
    end
  end

  task automatic push_sample(input int value, input logic is_last);
    sample_item_t itm;
    itm.sample = SAMPLE_W'(value);
    itm.last   = is_last;
    pending_samples.push_back(itm);
    samples_sent++;
    if (is_last) series_sent++;
  endtask

  task automatic push_random_series(input int len);
    int mode;
    int base;
    int step;
    int v;
    mode = $urandom_range(0, 4);
    base = $urandom;
    step = $urandom_range(1, 40);
    if (mode == 2) base = -32768 + $urandom_range(0, 8192);
    if (mode == 3) base = 32767 - $urandom_range(0, 8192);
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: v = $urandom;
        1: v = base + $urandom_range(0, 2);
        2: v = base + i * step + $urandom_range(0, step);
        3: v = base - i * step - $urandom_range(0, step);
        default: begin
          case ($urandom_range(0, 3))
            0:       v = -32768;
            1:       v = 32767;
            2:       v = 0;
            default: v = -1;
          endcase
        end
      endcase
      push_sample(v, i == len - 1);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_BAND_LOW:  band_lo = val;
      CFG_BAND_HIGH: band_hi = val;
      default: ;
    endcase
    band_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic drain_series();
    do @(posedge clk_i);
    while (pending_samples.size() != 0 || s_axis_tvalid || trend_results_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int lo;
    int hi;
    int len;
    int rand_items;
    int rand_series;
    rand_items  = 0;
    rand_series = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(posedge clk_i);

    // reset band: small series all fall below it
    push_sample(-32768, 1'b1);
    push_sample(32767, 1'b0);
    push_sample(32767, 1'b1);
    push_sample(-32768, 1'b0);
    push_sample(32767, 1'b1);
    push_sample(32767, 1'b0);
    push_sample(-32768, 1'b0);
    push_sample(0, 1'b0);
    push_sample(-1, 1'b0);
    push_sample(1, 1'b1);
    drain_series();

    write_reg(CFG_BAND_LOW, '0);
    write_reg(CFG_BAND_HIGH, '0);
    push_sample(5, 1'b0);
    push_sample(5, 1'b1);
    push_sample(1, 1'b0);
    push_sample(2, 1'b1);
    drain_series();

    write_reg(CFG_BAND_LOW, '1);
    write_reg(CFG_BAND_HIGH, '1);
    push_sample(-1, 1'b0);
    push_sample(0, 1'b1);
    drain_series();

    // crossed band: rising test wins
    write_reg(CFG_BAND_LOW, COUNT_W'(20));
    write_reg(CFG_BAND_HIGH, COUNT_W'(5));
    for (int i = 0; i < 5; i++) push_sample(i * 100 - 200, i == 4);
    drain_series();
    write_reg(CFG_SPARE_A, '0);
    write_reg(CFG_SPARE_B, '1);
    for (int i = 0; i < 3; i++) push_sample(i - 1, i == 2);
    drain_series();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      lo = $urandom_range(0, 80);
      if ($urandom_range(0, 3) == 0) hi = $urandom_range(0, lo);
      else hi = lo + $urandom_range(0, 80);
      write_reg(CFG_BAND_LOW, COUNT_W'(lo));
      write_reg(CFG_BAND_HIGH, COUNT_W'(hi));
      while (rand_items < (ph + 1) * RAND_ITEMS / RAND_PHASES ||
             rand_series < (ph + 1) * 5) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 24);
        push_random_series(len);
        rand_items  += len;
        rand_series++;
      end
      drain_series();
    end

    $display("Sent %0d samples in %0d series, %0d results checked, %0d register writes.",
             samples_sent, series_sent, results_seen, band_writes);
    $display("Covered ties, extremes, crossed and spare bands, and random series lengths.");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/itt_pkg.sv
hw/rtl/itt_datapath.sv
hw/rtl/itt_controller.sv
hw/rtl/inversion_trend_test.sv
hw/rtl/itt_checker.sv
sim/tb_inversion_trend_test.sv
